/* hw/rtl/pdds_pkg.sv */
package pdds_pkg;

   localparam int ERROR_WIDTH_DEFAULT = 16;
   localparam int GAIN_W              = 16;
   localparam int SPEED_W             = 16;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 16;
   localparam int STEP_W              = 4;

   localparam logic [GAIN_W-1:0]  PROP_NUM_RESET   = 16'd1;
   localparam logic [GAIN_W-1:0]  PROP_DEN_RESET   = 16'd1;
   localparam logic [GAIN_W-1:0]  DERIV_NUM_RESET  = 16'd0;
   localparam logic [GAIN_W-1:0]  DERIV_DEN_RESET  = 16'd1;
   localparam logic [SPEED_W-1:0] TOP_SPEED_RESET  = 16'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_NUM  = 3'd0,
      CSR_PROP_DEN  = 3'd1,
      CSR_DERIV_NUM = 3'd2,
      CSR_DERIV_DEN = 3'd3,
      CSR_TOP_SPEED = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_num;
      logic [GAIN_W-1:0]  prop_den;
      logic [GAIN_W-1:0]  deriv_num;
      logic [GAIN_W-1:0]  deriv_den;
      logic [SPEED_W-1:0] top_speed;
   } cfg_type;

   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_LATCH,
      UOP_MUL_P,
      UOP_MUL_D,
      UOP_DIV_START,
      UOP_ACC_P,
      UOP_ACC_D,
      UOP_EMIT
   } uop_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_DIV,
      HOLD_OUT_FULL
   } hold_type;

   typedef struct packed {
      uop_type           uop;
      hold_type          hold;
      logic [STEP_W-1:0] next_step;
   } cword_type;

   typedef struct packed {
      logic req_valid;
      logic div_busy;
      logic out_full;
   } status_type;

   // The control program: one word per step. A step repeats while its hold
   // condition is true and then moves to its successor.
   function automatic cword_type ucode_rom(input logic [STEP_W-1:0] step);
      cword_type cw;
      case (step)
         4'd0:    cw = '{uop: UOP_LATCH,     hold: HOLD_NO_REQ,   next_step: 4'd1};
         4'd1:    cw = '{uop: UOP_MUL_P,     hold: HOLD_NONE,     next_step: 4'd2};
         4'd2:    cw = '{uop: UOP_DIV_START, hold: HOLD_NONE,     next_step: 4'd3};
         4'd3:    cw = '{uop: UOP_NOP,       hold: HOLD_DIV,      next_step: 4'd4};
         4'd4:    cw = '{uop: UOP_ACC_P,     hold: HOLD_NONE,     next_step: 4'd5};
         4'd5:    cw = '{uop: UOP_MUL_D,     hold: HOLD_NONE,     next_step: 4'd6};
         4'd6:    cw = '{uop: UOP_DIV_START, hold: HOLD_NONE,     next_step: 4'd7};
         4'd7:    cw = '{uop: UOP_NOP,       hold: HOLD_DIV,      next_step: 4'd8};
         4'd8:    cw = '{uop: UOP_ACC_D,     hold: HOLD_NONE,     next_step: 4'd9};
         4'd9:    cw = '{uop: UOP_EMIT,      hold: HOLD_OUT_FULL, next_step: 4'd0};
         default: cw = '{uop: UOP_NOP,       hold: HOLD_NONE,     next_step: 4'd0};
      endcase
      return cw;
   endfunction

endpackage

/* hw/rtl/pdds_sequencer.sv */
module pdds_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  pdds_pkg::status_type  status,
   output pdds_pkg::uop_type     uop
);

   logic [pdds_pkg::STEP_W-1:0] step_ff;
   logic [pdds_pkg::STEP_W-1:0] step_in;
   pdds_pkg::cword_type         cw;
   logic                        held;

   assign cw  = pdds_pkg::ucode_rom(step_ff);
   assign uop = cw.uop;

   always_comb begin
      case (cw.hold)
         pdds_pkg::HOLD_NONE:     held = 1'b0;
         pdds_pkg::HOLD_NO_REQ:   held = !status.req_valid;
         pdds_pkg::HOLD_DIV:      held = status.div_busy;
         pdds_pkg::HOLD_OUT_FULL: held = status.out_full;
         default:                 held = 1'b0;
      endcase
   end

   assign step_in = held ? step_ff : cw.next_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* hw/rtl/pdds_divider.sv */
module pdds_divider #(
   parameter int DIVIDEND_W = pdds_pkg::ERROR_WIDTH_DEFAULT + pdds_pkg::GAIN_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIVIDEND_W-1:0]       dividend,
   input  logic [pdds_pkg::GAIN_W-1:0] divisor,
   output logic                        busy,
   output logic [DIVIDEND_W-1:0]       quotient
);

   localparam int DW    = pdds_pkg::GAIN_W;
   localparam int STEPS = (DIVIDEND_W + 1) / 2;
   localparam int QW    = 2 * STEPS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [QW-1:0]    quo_ff;
   logic [QW-1:0]    quo_in;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    rem_in;
   logic [DW-1:0]    div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [DW:0]      trial1;
   logic [DW:0]      trial2;
   logic [DW:0]      diff1;
   logic [DW:0]      diff2;
   logic [DW-1:0]    rem1;
   logic             ge1;
   logic             ge2;

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff[DIVIDEND_W-1:0];

   // Two restoring steps per cycle: two quotient bits a cycle.
   always_comb begin
      trial1 = {rem_ff, quo_ff[QW-1]};
      ge1    = (trial1 >= {1'b0, div_ff});
      diff1  = trial1 - {1'b0, div_ff};
      rem1   = ge1 ? diff1[DW-1:0] : trial1[DW-1:0];
      trial2 = {rem1, quo_ff[QW-2]};
      ge2    = (trial2 >= {1'b0, div_ff});
      diff2  = trial2 - {1'b0, div_ff};
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = QW'(dividend);
         rem_in = '0;
         cnt_in = CNT_W'(STEPS);
      end else if (busy) begin
         quo_in = {quo_ff[QW-3:0], ge1, ge2};
         rem_in = ge2 ? diff2[DW-1:0] : trial2[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

endmodule

/* hw/rtl/pdds_datapath.sv */
module pdds_datapath #(
   parameter int ERROR_WIDTH = pdds_pkg::ERROR_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pdds_pkg::uop_type                   uop,
   input  pdds_pkg::cfg_type                   cfg,
   output pdds_pkg::status_type                status,
   input  logic                                req_valid,
   input  logic signed [ERROR_WIDTH-1:0]       req_error_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pdds_pkg::SPEED_W-1:0]        rsp_left_speed,
   output logic [pdds_pkg::SPEED_W-1:0]        rsp_right_speed
);

   localparam int W      = ERROR_WIDTH;
   localparam int GW     = pdds_pkg::GAIN_W;
   localparam int SW     = pdds_pkg::SPEED_W;
   localparam int MAG_W  = W + GW;
   localparam int DIFF_W = MAG_W + 2;
   localparam int SUM_W  = DIFF_W + 1;

   logic signed [W-1:0]      error_ff;
   logic signed [W-1:0]      prev_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [GW-1:0]            den_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic                     rsp_valid_ff;
   logic [SW-1:0]            left_ff;
   logic [SW-1:0]            right_ff;

   logic signed [W:0]        operand;
   logic [W:0]               operand_abs;
   logic [GW-1:0]            num_sel;
   logic [GW-1:0]            den_sel;
   logic [W+GW:0]            product;
   logic                     div_busy;
   logic [MAG_W-1:0]         quotient;
   logic signed [MAG_W:0]    quotient_s;
   logic signed [SUM_W-1:0]  top_s;
   logic signed [SUM_W-1:0]  left_sum;
   logic signed [SUM_W-1:0]  right_sum;
   logic                     out_full;
   logic                     is_mul;

   assign is_mul = (uop == pdds_pkg::UOP_MUL_P) || (uop == pdds_pkg::UOP_MUL_D);

   // Proportional step scales the error, derivative step the change in error.
   always_comb begin
      if (uop == pdds_pkg::UOP_MUL_D) begin
         operand = {error_ff[W-1], error_ff} - {prev_ff[W-1], prev_ff};
         num_sel = cfg.deriv_num;
         den_sel = cfg.deriv_den;
      end else begin
         operand = {error_ff[W-1], error_ff};
         num_sel = cfg.prop_num;
         den_sel = cfg.prop_den;
      end
      operand_abs = operand[W] ? (~operand) + 1'b1 : operand;
      product     = operand_abs * num_sel;
   end

   pdds_divider #(
      .DIVIDEND_W (MAG_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (uop == pdds_pkg::UOP_DIV_START),
      .dividend (mag_ff),
      .divisor  (den_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Truncation toward zero: divide magnitudes, then restore the sign.
   assign quotient_s = neg_ff ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});

   assign top_s     = $signed({{(SUM_W-SW){1'b0}}, cfg.top_speed});
   assign left_sum  = top_s + SUM_W'(diff_ff);
   assign right_sum = top_s - SUM_W'(diff_ff);

   function automatic logic [SW-1:0] clamp_speed(input logic signed [SUM_W-1:0] v,
                                                 input logic signed [SUM_W-1:0] top);
      logic [SW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > top) begin
         r = top[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   assign out_full = rsp_valid_ff && rsp_stall;

   assign status.req_valid = req_valid;
   assign status.div_busy  = div_busy;
   assign status.out_full  = out_full;

   always_ff @(posedge clock) begin
      if (uop == pdds_pkg::UOP_LATCH && req_valid) begin
         error_ff <= req_error_value;
      end
      if (is_mul) begin
         mag_ff <= product[MAG_W-1:0];
         neg_ff <= operand[W];
         den_ff <= (den_sel == '0) ? GW'(1) : den_sel;
      end
      if (uop == pdds_pkg::UOP_ACC_P) begin
         diff_ff <= DIFF_W'(quotient_s);
      end else if (uop == pdds_pkg::UOP_ACC_D) begin
         diff_ff <= diff_ff + DIFF_W'(quotient_s);
      end
      if (uop == pdds_pkg::UOP_EMIT && !out_full) begin
         left_ff  <= clamp_speed(left_sum, top_s);
         right_ff <= clamp_speed(right_sum, top_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (uop == pdds_pkg::UOP_MUL_D) begin
            prev_ff <= error_ff;
         end
         if (uop == pdds_pkg::UOP_EMIT && !out_full) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;

endmodule

/* hw/rtl/pd_differential_speed.sv */
// Proportional-derivative steering for a two-wheel drive. Each transaction on
// the req_ channel carries one signed position error; the block returns one
// rsp_ transaction holding the left and right wheel speeds, each clamped to
// 0..top_speed. The proportional and derivative fractions are computed with a
// small multiplier and one shared iterative divider that retires two quotient
// bits a cycle, all sequenced by a ten-step control program. The next error
// is accepted only when the program has returned to its first step, after
// both divider passes of the current item. A finished result waits in the
// output register without holding up the next error. Gain and speed
// registers are written through the csr_ port; the user must write them only
// while no transaction is in progress, as the block does not enforce this. A
// zero denominator acts as one.
module pd_differential_speed #(
   parameter int ERROR_WIDTH = pdds_pkg::ERROR_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pdds_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pdds_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ERROR_WIDTH-1:0]        req_error_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [pdds_pkg::SPEED_W-1:0]         rsp_left_speed,
   output logic [pdds_pkg::SPEED_W-1:0]         rsp_right_speed
);

   pdds_pkg::cfg_type    cfg_ff;
   pdds_pkg::uop_type    uop;
   pdds_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_num  <= pdds_pkg::PROP_NUM_RESET;
         cfg_ff.prop_den  <= pdds_pkg::PROP_DEN_RESET;
         cfg_ff.deriv_num <= pdds_pkg::DERIV_NUM_RESET;
         cfg_ff.deriv_den <= pdds_pkg::DERIV_DEN_RESET;
         cfg_ff.top_speed <= pdds_pkg::TOP_SPEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pdds_pkg::CSR_PROP_NUM:  cfg_ff.prop_num  <= csr_write_data;
            pdds_pkg::CSR_PROP_DEN:  cfg_ff.prop_den  <= csr_write_data;
            pdds_pkg::CSR_DERIV_NUM: cfg_ff.deriv_num <= csr_write_data;
            pdds_pkg::CSR_DERIV_DEN: cfg_ff.deriv_den <= csr_write_data;
            pdds_pkg::CSR_TOP_SPEED: cfg_ff.top_speed <= csr_write_data;
            default: ;
         endcase
      end
   end

   pdds_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uop    (uop)
   );

   assign req_stall = (uop != pdds_pkg::UOP_LATCH);

   pdds_datapath #(
      .ERROR_WIDTH (ERROR_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .uop             (uop),
      .cfg             (cfg_ff),
      .status          (status),
      .req_valid       (req_valid),
      .req_error_value (req_error_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed)
   );

endmodule

/* verif/pd_differential_speed_checker.sv */
`timescale 1ns / 100ps

module pd_differential_speed_checker #(
   parameter int ERROR_WIDTH = pdds_pkg::ERROR_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [pdds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pdds_pkg::CSR_DATA_W-1:0]   csr_write_data,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [ERROR_WIDTH-1:0]     req_error_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [pdds_pkg::SPEED_W-1:0]      rsp_left_speed,
   input  logic [pdds_pkg::SPEED_W-1:0]      rsp_right_speed,
   output int                                mismatch_count,
   output int                                pending_count
);

   typedef struct packed {
      logic [pdds_pkg::SPEED_W-1:0] left;
      logic [pdds_pkg::SPEED_W-1:0] right;
   } wheel_pair_type;

   pdds_pkg::cfg_type             gains;
   logic signed [ERROR_WIDTH-1:0] last_error;
   wheel_pair_type                wheel_queue[$];
   int                            mismatches = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = wheel_queue.size();

   // Multiplies by a gain fraction; SystemVerilog division of signed values
   // already truncates toward zero. A zero denominator behaves as one.
   function automatic longint scale_by_gain(input longint x,
                                            input logic [pdds_pkg::GAIN_W-1:0] num,
                                            input logic [pdds_pkg::GAIN_W-1:0] den);
      longint numerator;
      longint divisor;
      numerator = num;
      divisor   = den;
      if (divisor == 0) divisor = 1;
      return (x * numerator) / divisor;
   endfunction

   function automatic logic [pdds_pkg::SPEED_W-1:0] limit_speed(input longint v,
                                                               input longint top);
      if (v < 0) return '0;
      if (v > top) return top[pdds_pkg::SPEED_W-1:0];
      return v[pdds_pkg::SPEED_W-1:0];
   endfunction

   function automatic wheel_pair_type steer(input logic signed [ERROR_WIDTH-1:0] err);
      longint         e;
      longint         prev;
      longint         diff;
      longint         top;
      wheel_pair_type w;
      e    = err;
      prev = last_error;
      top  = gains.top_speed;
      diff = scale_by_gain(e, gains.prop_num, gains.prop_den)
           + scale_by_gain(e - prev, gains.deriv_num, gains.deriv_den);
      w.left  = limit_speed(top + diff, top);
      w.right = limit_speed(top - diff, top);
      return w;
   endfunction

   always @(posedge clock) begin : track
      wheel_pair_type expected;
      if (reset) begin
         gains = '{prop_num:  pdds_pkg::PROP_NUM_RESET,
                   prop_den:  pdds_pkg::PROP_DEN_RESET,
                   deriv_num: pdds_pkg::DERIV_NUM_RESET,
                   deriv_den: pdds_pkg::DERIV_DEN_RESET,
                   top_speed: pdds_pkg::TOP_SPEED_RESET};
         last_error = '0;
         wheel_queue.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               pdds_pkg::CSR_PROP_NUM:  gains.prop_num  = csr_write_data;
               pdds_pkg::CSR_PROP_DEN:  gains.prop_den  = csr_write_data;
               pdds_pkg::CSR_DERIV_NUM: gains.deriv_num = csr_write_data;
               pdds_pkg::CSR_DERIV_DEN: gains.deriv_den = csr_write_data;
               pdds_pkg::CSR_TOP_SPEED: gains.top_speed = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            wheel_queue.push_back(steer(req_error_value));
            last_error = req_error_value;
         end
         if (rsp_valid && !rsp_stall) begin
            if (wheel_queue.size() == 0) begin
               $error("Unexpected rsp transaction: left_speed %0d, right_speed %0d",
                      rsp_left_speed, rsp_right_speed);
               mismatches++;
            end else begin
               expected = wheel_queue.pop_front();
               if (rsp_left_speed !== expected.left) begin
                  $error("left_speed: expected %0d, actual %0d", expected.left, rsp_left_speed);
                  mismatches++;
               end
               if (rsp_right_speed !== expected.right) begin
                  $error("right_speed: expected %0d, actual %0d",
                         expected.right, rsp_right_speed);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule

/* verif/pd_differential_speed_tb.sv */
`timescale 1ns / 100ps

module pd_differential_speed_tb;

   localparam int CLOCK_HALF      = 10;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int SETTLE_CYCLES   = 60;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_PHASES   = 9;
   localparam int PHASE_ITEMS     = 200;
   localparam int EW              = pdds_pkg::ERROR_WIDTH_DEFAULT;
   localparam int IW              = pdds_pkg::CSR_INDEX_W;
   localparam int DW              = pdds_pkg::CSR_DATA_W;
   localparam int GW              = pdds_pkg::GAIN_W;
   localparam int SW              = pdds_pkg::SPEED_W;
   localparam logic [IW-1:0] STRAY_INDEX_FIRST = IW'(pdds_pkg::CSR_TOP_SPEED + 1);

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [IW-1:0]        csr_index        = '0;
   logic [DW-1:0]        csr_write_data   = '0;
   logic                 req_valid        = 1'b0;
   logic signed [EW-1:0] req_error_value  = '0;
   logic                 rsp_stall        = 1'b0;
   logic                 req_stall;
   logic                 rsp_valid;
   logic [SW-1:0]        rsp_left_speed;
   logic [SW-1:0]        rsp_right_speed;

   int mismatch_count;
   int pending_count;
   int cycle_count     = 0;
   int idle_pct        = 0;
   int stall_pct       = 0;
   bit quiet           = 1'b0;
   int hold_off_asked  = 0;
   int hold_off_served = 0;
   logic signed [EW-1:0] last_sent = '0;

   pd_differential_speed DUT (.*);

   pd_differential_speed_checker wheel_check (.*);

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus a long hold-off whenever one is asked for.
   initial begin : rsp_side
      int burst;
      forever begin
         @(posedge clock);
         if (hold_off_served < hold_off_asked) begin
            hold_off_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(99) < stall_pct) begin
            burst = $urandom_range(5, 1);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_error(input logic signed [EW-1:0] err);
      int gap;
      if (!quiet && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(5, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_error_value <= err;
      last_sent        = err;
      do @(posedge clock); while (req_stall);
   endtask

   // Leaves the sender idle until every expected transaction has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IW-1:0] idx,
                            input logic [DW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   task automatic set_gains(input logic [GW-1:0] pnum, input logic [GW-1:0] pden,
                            input logic [GW-1:0] dnum, input logic [GW-1:0] dden,
                            input logic [SW-1:0] top, input bit stray);
      if (stray) write_reg(STRAY_INDEX_FIRST + IW'($urandom_range(2)),
                           DW'($urandom()));
      write_reg(pdds_pkg::CSR_PROP_NUM, pnum);
      write_reg(pdds_pkg::CSR_PROP_DEN, pden);
      write_reg(pdds_pkg::CSR_DERIV_NUM, dnum);
      write_reg(pdds_pkg::CSR_DERIV_DEN, dden);
      write_reg(pdds_pkg::CSR_TOP_SPEED, top);
      if (stray) write_reg(STRAY_INDEX_FIRST + IW'($urandom_range(2)),
                           DW'($urandom()));
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [GW-1:0] pick_numerator();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         2, 3:    return GW'($urandom_range(16));
         default: return GW'($urandom());
      endcase
   endfunction

   // A zero denominator is exercised on purpose: the block treats it as one.
   function automatic logic [GW-1:0] pick_denominator();
      case ($urandom_range(6))
         0:       return '0;
         1:       return GW'(1);
         2:       return '1;
         3, 4:    return GW'($urandom_range(16, 1));
         default: return GW'($urandom());
      endcase
   endfunction

   function automatic logic [SW-1:0] pick_top_speed();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return SW'($urandom());
      endcase
   endfunction

   // Often a slowly wandering error, as a real track gives, so that the
   // derivative term stays small enough to show up without clamping.
   function automatic logic signed [EW-1:0] pick_error();
      case ($urandom_range(9))
         0:          return 16'sh8000;
         1:          return 16'sh7FFF;
         2, 3:       return 16'($urandom_range(400)) - 16'd200;
         4, 5, 6, 7: return last_sent + 16'($urandom_range(40)) - 16'd20;
         default:    return 16'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Gains as they come out of reset.
      idle_pct  = 20;
      stall_pct = 20;
      send_error(16'sd0);
      send_error(16'sd1);
      send_error(-16'sd1);
      send_error(16'sh7FFF);
      send_error(16'sh8000);
      wait_drained();

      // Largest gains with zero denominators and the full speed range.
      set_gains('1, '0, '1, '0, '1, 1'b0);
      send_error(16'sh7FFF);
      send_error(16'sh8000);
      send_error(16'sh7FFF);
      send_error(16'sd0);
      send_error(-16'sd1);
      wait_drained();

      // No proportional gain, tiny derivative gain, top speed of zero.
      set_gains('0, '1, GW'(1), '1, '0, 1'b0);
      send_error(16'sh8000);
      send_error(16'sh7FFF);
      send_error(16'sd5);
      wait_drained();

      // Moderate fractions that truncate, with writes to unused indexes around them.
      set_gains(GW'(3), GW'(7), GW'(5), GW'(3), SW'(30000), 1'b1);
      send_error(-16'sd100);
      send_error(16'sd100);
      send_error(-16'sd7);
      send_error(16'sd7);
      send_error(16'sd12345);
      send_error(-16'sd12345);
      wait_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         quiet = (phase == RANDOM_PHASES - 1);
         case ($urandom_range(2))
            0:       idle_pct = 0;
            1:       idle_pct = 15;
            default: idle_pct = 40;
         endcase
         case ($urandom_range(2))
            0:       stall_pct = 0;
            1:       stall_pct = 15;
            default: stall_pct = 40;
         endcase
         set_gains(pick_numerator(), pick_denominator(), pick_numerator(),
                   pick_denominator(), pick_top_speed(), phase % 3 == 0);
         if (phase == 2) hold_off_asked++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 5 && n == PHASE_ITEMS / 2) wait_drained();
            send_error(pick_error());
         end
         wait_drained();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
